// File: rtl/fspsa_pkg.sv
package fspsa_pkg;

    // normalized magnitude, cordic datapath, angle accumulator and angle widths
    localparam int NORM_W    = 32;
    localparam int CORDIC_W  = 36;
    localparam int ZW        = 33;
    localparam int ANG_W     = 33;
    localparam int OUT_W     = 15;
    localparam int ANG_FRAC  = 30;
    localparam int TABLE_LEN = 24;

    // radians * 2^30
    localparam logic [ANG_W-1:0] PI_Q30        = 33'd3373259426;
    localparam logic [ANG_W-1:0] HALF_PI_Q30   = 33'd1686629713;
    localparam logic [ANG_W-1:0] THR_HALF_Q30  = 33'd5059889139;
    localparam logic [ANG_W-1:0] FULL_Q30      = 33'd6746518852;

    // where the angle comes from
    typedef enum logic [2:0] {
        SECT_Q1,
        SECT_Q2,
        SECT_Q3,
        SECT_Q4,
        SECT_HALF_PI,
        SECT_PI,
        SECT_THR_HALF_PI,
        SECT_FULL
    } sect_t;

    typedef struct packed {
        logic  valid;
        sect_t sect;
    } tag_t;

    // atan(2^-i) in radians * 2^30, truncated
    function automatic logic [ZW-1:0] atan_q30(input int idx);
        logic [ZW-1:0] val;
        begin
            unique case (idx)
                0:       val = 33'd843314856;
                1:       val = 33'd497837829;
                2:       val = 33'd263043836;
                3:       val = 33'd133525158;
                4:       val = 33'd67021686;
                5:       val = 33'd33543515;
                6:       val = 33'd16775850;
                7:       val = 33'd8388437;
                8:       val = 33'd4194282;
                9:       val = 33'd2097149;
                10:      val = 33'd1048575;
                11:      val = 33'd524287;
                12:      val = 33'd262143;
                13:      val = 33'd131071;
                14:      val = 33'd65535;
                15:      val = 33'd32767;
                16:      val = 33'd16383;
                17:      val = 33'd8191;
                18:      val = 33'd4095;
                19:      val = 33'd2047;
                20:      val = 33'd1023;
                21:      val = 33'd511;
                22:      val = 33'd255;
                23:      val = 33'd127;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// File: rtl/four_step_phase_shift_angle_unit.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  first_intensity .. fourth_intensity
// out      output     out_valid / out_stall wrapped_phase
//
// one pixel per clock while out_stall is low; each pixel passes the normalize stages,
// then the cordic stages, one iteration per stage, and the map/round tail
// rst_n clears every stage valid bit at once; no clearing pass
// each stage holds while the next one is full and held, so bubbles close up
// and in_stall rises only when every stage up to the output register is full
module four_step_phase_shift_angle_unit import fspsa_pkg::*; #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int PHASE_FRAC_BITS = 12,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] first_intensity,
    input  logic signed [SAMPLE_WIDTH-1:0] second_intensity,
    input  logic signed [SAMPLE_WIDTH-1:0] third_intensity,
    input  logic signed [SAMPLE_WIDTH-1:0] fourth_intensity,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [OUT_W-1:0]               wrapped_phase
);

    tag_t                       tag_w [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0] x_w   [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0] y_w   [CORDIC_STAGES+1];
    logic signed [ZW-1:0]       z_w   [CORDIC_STAGES+1];
    logic                       en_w  [CORDIC_STAGES+1];

    logic              prep_en;
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;

    assign in_stall = !prep_en;

    fspsa_prep #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_prep (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .first_intensity  (first_intensity),
        .second_intensity (second_intensity),
        .third_intensity  (third_intensity),
        .fourth_intensity (fourth_intensity),
        .out_en           (en_w[0]),
        .in_en            (prep_en),
        .out_tag          (tag_w[0]),
        .out_ax           (ax),
        .out_ay           (ay)
    );

    assign x_w[0] = CORDIC_W'(ax);
    assign y_w[0] = CORDIC_W'(ay);
    assign z_w[0] = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        fspsa_cordic_stage #(
            .IDX(i)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_tag  (tag_w[i]),
            .in_x    (x_w[i]),
            .in_y    (y_w[i]),
            .in_z    (z_w[i]),
            .out_en  (en_w[i+1]),
            .in_en   (en_w[i]),
            .out_tag (tag_w[i+1]),
            .out_x   (x_w[i+1]),
            .out_y   (y_w[i+1]),
            .out_z   (z_w[i+1])
        );
    end

    fspsa_post #(
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (tag_w[CORDIC_STAGES]),
        .in_z      (z_w[CORDIC_STAGES]),
        .out_stall (out_stall),
        .in_en     (en_w[CORDIC_STAGES]),
        .out_valid (out_valid),
        .out_phase (wrapped_phase)
    );

endmodule

// File: rtl/fspsa_prep.sv
module fspsa_prep import fspsa_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] first_intensity,
    input  logic signed [SAMPLE_WIDTH-1:0] second_intensity,
    input  logic signed [SAMPLE_WIDTH-1:0] third_intensity,
    input  logic signed [SAMPLE_WIDTH-1:0] fourth_intensity,
    input  logic                           out_en,
    output logic                           in_en,
    output tag_t                           out_tag,
    output logic [NORM_W-1:0]              out_ax,
    output logic [NORM_W-1:0]              out_ay
);

    localparam int DW = SAMPLE_WIDTH + 1;

    logic                 v1_reg;
    logic signed [DW-1:0] den_reg;
    logic signed [DW-1:0] num_reg;
    tag_t                 tag2_reg;
    logic [NORM_W-1:0]    ax2_reg;
    logic [NORM_W-1:0]    ay2_reg;
    tag_t                 tag3_reg;
    logic [NORM_W-1:0]    ax3_reg;
    logic [NORM_W-1:0]    ay3_reg;
    tag_t                 tag4_reg;
    logic [NORM_W-1:0]    ax4_reg;
    logic [NORM_W-1:0]    ay4_reg;

    logic en1, en2, en3, en4;

    logic signed [DW-1:0] den_next;
    logic signed [DW-1:0] num_next;
    logic [DW-1:0]        den_mag;
    logic [DW-1:0]        num_mag;
    sect_t                sect_next;
    logic [NORM_W-1:0]    ax3_next;
    logic [NORM_W-1:0]    ay3_next;
    logic [NORM_W-1:0]    ax4_next;
    logic [NORM_W-1:0]    ay4_next;

    assign en4   = !tag4_reg.valid || out_en;
    assign en3   = !tag3_reg.valid || en4;
    assign en2   = !tag2_reg.valid || en3;
    assign en1   = !v1_reg || en2;
    assign in_en = en1;

    assign den_next = DW'(first_intensity) - DW'(third_intensity);
    assign num_next = DW'(fourth_intensity) - DW'(second_intensity);

    assign den_mag = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
    assign num_mag = num_reg[DW-1] ? DW'(-num_reg) : DW'(num_reg);

    always_comb
    begin
        priority if (num_reg == '0)
        begin
            sect_next = (!den_reg[DW-1] && den_reg != '0) ? SECT_FULL : SECT_PI;
        end
        else if (den_reg == '0)
        begin
            sect_next = num_reg[DW-1] ? SECT_THR_HALF_PI : SECT_HALF_PI;
        end
        else if (!num_reg[DW-1])
        begin
            sect_next = den_reg[DW-1] ? SECT_Q2 : SECT_Q1;
        end
        else
        begin
            sect_next = den_reg[DW-1] ? SECT_Q3 : SECT_Q4;
        end
    end

    // leading zero shift, coarse steps
    always_comb
    begin
        ax3_next = ax2_reg;
        ay3_next = ay2_reg;
        if ((ax3_next[NORM_W-1:NORM_W-16] | ay3_next[NORM_W-1:NORM_W-16]) == '0)
        begin
            ax3_next = ax3_next << 16;
            ay3_next = ay3_next << 16;
        end
        if ((ax3_next[NORM_W-1:NORM_W-8] | ay3_next[NORM_W-1:NORM_W-8]) == '0)
        begin
            ax3_next = ax3_next << 8;
            ay3_next = ay3_next << 8;
        end
    end

    // fine steps
    always_comb
    begin
        ax4_next = ax3_reg;
        ay4_next = ay3_reg;
        if ((ax4_next[NORM_W-1:NORM_W-4] | ay4_next[NORM_W-1:NORM_W-4]) == '0)
        begin
            ax4_next = ax4_next << 4;
            ay4_next = ay4_next << 4;
        end
        if ((ax4_next[NORM_W-1:NORM_W-2] | ay4_next[NORM_W-1:NORM_W-2]) == '0)
        begin
            ax4_next = ax4_next << 2;
            ay4_next = ay4_next << 2;
        end
        if ((ax4_next[NORM_W-1] | ay4_next[NORM_W-1]) == 1'b0)
        begin
            ax4_next = ax4_next << 1;
            ay4_next = ay4_next << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            tag2_reg <= '{valid: 1'b0, sect: SECT_PI};
            tag3_reg <= '{valid: 1'b0, sect: SECT_PI};
            tag4_reg <= '{valid: 1'b0, sect: SECT_PI};
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                tag2_reg <= '{valid: v1_reg, sect: sect_next};
            end
            if (en3)
            begin
                tag3_reg <= tag2_reg;
            end
            if (en4)
            begin
                tag4_reg <= tag3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            den_reg <= den_next;
            num_reg <= num_next;
        end
        if (en2)
        begin
            ax2_reg <= NORM_W'(den_mag);
            ay2_reg <= NORM_W'(num_mag);
        end
        if (en3)
        begin
            ax3_reg <= ax3_next;
            ay3_reg <= ay3_next;
        end
        if (en4)
        begin
            ax4_reg <= ax4_next;
            ay4_reg <= ay4_next;
        end
    end

    assign out_tag = tag4_reg;
    assign out_ax  = ax4_reg;
    assign out_ay  = ay4_reg;

endmodule

// File: rtl/fspsa_cordic_stage.sv
module fspsa_cordic_stage import fspsa_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tag_t                       in_tag,
    input  logic signed [CORDIC_W-1:0] in_x,
    input  logic signed [CORDIC_W-1:0] in_y,
    input  logic signed [ZW-1:0]       in_z,
    input  logic                       out_en,
    output logic                       in_en,
    output tag_t                       out_tag,
    output logic signed [CORDIC_W-1:0] out_x,
    output logic signed [CORDIC_W-1:0] out_y,
    output logic signed [ZW-1:0]       out_z
);

    localparam logic signed [ZW-1:0] ATAN_STEP = atan_q30(IDX);

    tag_t                       tag_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ZW-1:0]       z_reg;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [ZW-1:0]       z_next;
    logic                       en;

    assign en    = !tag_reg.valid || out_en;
    assign in_en = en;

    // rotate toward the x axis
    always_comb
    begin
        if (!in_y[CORDIC_W-1])
        begin
            x_next = in_x + (in_y >>> IDX);
            y_next = in_y - (in_x >>> IDX);
            z_next = in_z + ATAN_STEP;
        end
        else
        begin
            x_next = in_x - (in_y >>> IDX);
            y_next = in_y + (in_x >>> IDX);
            z_next = in_z - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '{valid: 1'b0, sect: SECT_PI};
        end
        else if (en)
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_tag = tag_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_z   = z_reg;

endmodule

// File: rtl/fspsa_post.sv
module fspsa_post import fspsa_pkg::*; #(
    parameter int PHASE_FRAC_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tag_t                  in_tag,
    input  logic signed [ZW-1:0]  in_z,
    input  logic                  out_stall,
    output logic                  in_en,
    output logic                  out_valid,
    output logic [OUT_W-1:0]      out_phase
);

    localparam int               SH       = ANG_FRAC - PHASE_FRAC_BITS;
    localparam logic [ANG_W:0]   RND_HALF = (ANG_W+1)'(1) << (SH - 1);
    localparam logic [ANG_W:0]   FULL_RND = ((ANG_W+1)'(FULL_Q30) + RND_HALF) >> SH;
    localparam logic [OUT_W-1:0] FULL_OUT = OUT_W'(FULL_RND);

    tag_t             tag1_reg;
    logic [ANG_W-1:0] zc_reg;
    logic             v2_reg;
    logic [ANG_W-1:0] ang_reg;
    logic             v3_reg;
    logic [OUT_W-1:0] phase_reg;

    logic             en1, en2, en3;
    logic [ANG_W-1:0] zc_next;
    logic [ANG_W-1:0] ang_next;
    logic [ANG_W:0]   rnd;
    logic [ANG_W:0]   rnd_shifted;
    logic [OUT_W-1:0] phase_next;

    assign en3   = !v3_reg || !out_stall;
    assign en2   = !v2_reg || en3;
    assign en1   = !tag1_reg.valid || en2;
    assign in_en = en1;

    // clamp to the first quadrant
    always_comb
    begin
        priority if (in_z[ZW-1])
        begin
            zc_next = '0;
        end
        else if (ANG_W'(in_z) > HALF_PI_Q30)
        begin
            zc_next = HALF_PI_Q30;
        end
        else
        begin
            zc_next = ANG_W'(in_z);
        end
    end

    always_comb
    begin
        unique case (tag1_reg.sect)
            SECT_Q1:          ang_next = zc_reg;
            SECT_Q2:          ang_next = PI_Q30 - zc_reg;
            SECT_Q3:          ang_next = PI_Q30 + zc_reg;
            SECT_Q4:          ang_next = FULL_Q30 - zc_reg;
            SECT_HALF_PI:     ang_next = HALF_PI_Q30;
            SECT_PI:          ang_next = PI_Q30;
            SECT_THR_HALF_PI: ang_next = THR_HALF_Q30;
            SECT_FULL:        ang_next = FULL_Q30;
            default:          ang_next = PI_Q30;
        endcase
    end

    // round half up, zero wraps to full turn
    assign rnd         = (ANG_W+1)'(ang_reg) + RND_HALF;
    assign rnd_shifted = rnd >> SH;
    assign phase_next  = (rnd_shifted == '0) ? FULL_OUT : OUT_W'(rnd_shifted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '{valid: 1'b0, sect: SECT_PI};
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                tag1_reg <= in_tag;
            end
            if (en2)
            begin
                v2_reg <= tag1_reg.valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            zc_reg <= zc_next;
        end
        if (en2)
        begin
            ang_reg <= ang_next;
        end
        if (en3)
        begin
            phase_reg <= phase_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_phase = phase_reg;

endmodule
